// ===== hdl/dtg_pkg.sv =====
package dtg_pkg;

    localparam int DEF_PHASE_BITS      = 16;
    localparam int DEF_TABLE_ADDR_BITS = 8;
    localparam int STEP_BITS           = 16;
    localparam int DUR_BITS            = 32;
    localparam int LEVEL_BITS          = 8;
    localparam int ROM_ADDR_BITS       = 8;
    localparam int ROM_DEPTH           = 1 << ROM_ADDR_BITS;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_TONE    = 2'd1,
        MODE_SILENCE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]           mode;
        logic [STEP_BITS-1:0] phase_step;
        logic [DUR_BITS-1:0]  duration_samples;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  active;
        logic                  status;
    } t_out_item;

    // Unsigned offset sine, one full period over the table.
    localparam logic [LEVEL_BITS-1:0] SINE_ROM [ROM_DEPTH] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
        8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
        8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
        8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
        8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
        8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
        8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
        8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
        8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
        8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
        8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
        8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
        8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
        8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
        8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
        8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
        8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
        8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
        8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
        8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
        8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
        8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
        8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
        8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
    };

endpackage

// ===== hdl/dds_tone_generator_with_duration_top.sv =====
// Tone generator by direct digital synthesis with a sample-count duration. Each input
// transfer is a sample tick, a tone command or a silence command, and each one yields
// exactly one result transfer carrying the current level, whether a tone or silence is
// still running, and a busy flag for a command that arrived while running (that command
// changes nothing). An item passes an input register and the logic (phase add,
// sine table read, count decrement) into the result register, so the block takes one
// item every cycle unless the output stalls; the phase update that each tick feeds
// to the next sets that rate.
module dds_tone_generator_with_duration_top
    import dtg_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic     w_reg_valid;
    t_in_item w_reg_item;
    logic     w_take;

    dtg_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .i_take  (w_take),
        .o_valid (w_reg_valid),
        .o_item  (w_reg_item)
    );

    dtg_core #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_reg_valid),
        .i_item      (w_reg_item),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== hdl/dtg_in_reg.sv =====
module dtg_in_reg
    import dtg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    // The register refills in the same cycle its content moves on.
    assign w_load  = !r_valid || i_take;
    assign o_stall = !w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/dtg_core.sv =====
module dtg_core
    import dtg_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_take,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int PH_SHIFT = PHASE_BITS - TABLE_ADDR_BITS;

    logic [PHASE_BITS-1:0]      r_phase_acc, n_phase_acc;
    logic [PHASE_BITS-1:0]      r_phase_inc, n_phase_inc;
    logic [DUR_BITS-1:0]        r_remaining, n_remaining;
    logic                       r_running, n_running;
    logic [LEVEL_BITS-1:0]      r_held_level, n_held_level;
    logic                       r_out_valid;
    t_out_item                  r_out_item, n_out_item;

    logic [PHASE_BITS-1:0]      w_phase_sum;
    logic [TABLE_ADDR_BITS-1:0] w_tab_addr;
    logic [ROM_ADDR_BITS-1:0]   w_rom_addr;
    logic [DUR_BITS-1:0]        w_rem_dec;
    logic                       w_status;

    assign o_take      = i_valid && (!r_out_valid || !i_out_stall);
    assign w_phase_sum = r_phase_acc + r_phase_inc;
    assign w_rem_dec   = r_remaining - DUR_BITS'(1);

    generate
        if (PH_SHIFT >= 0) begin : g_addr_down
            assign w_tab_addr = TABLE_ADDR_BITS'(w_phase_sum >> PH_SHIFT);
        end else begin : g_addr_up
            assign w_tab_addr = TABLE_ADDR_BITS'(
                {{TABLE_ADDR_BITS{1'b0}}, w_phase_sum} << (-PH_SHIFT));
        end
        if (TABLE_ADDR_BITS <= ROM_ADDR_BITS) begin : g_rom_up
            assign w_rom_addr = ROM_ADDR_BITS'(
                {w_tab_addr, {ROM_ADDR_BITS{1'b0}}} >> TABLE_ADDR_BITS);
        end else begin : g_rom_down
            assign w_rom_addr = ROM_ADDR_BITS'(
                w_tab_addr >> (TABLE_ADDR_BITS - ROM_ADDR_BITS));
        end
    endgenerate

    always_comb begin
        n_phase_acc  = r_phase_acc;
        n_phase_inc  = r_phase_inc;
        n_remaining  = r_remaining;
        n_running    = r_running;
        n_held_level = r_held_level;
        w_status     = 1'b0;
        unique case (i_item.mode)
            MODE_TICK: begin
                if (r_running) begin
                    n_phase_acc  = w_phase_sum;
                    n_held_level = SINE_ROM[w_rom_addr];
                    n_remaining  = w_rem_dec;
                    n_running    = (w_rem_dec != '0);
                end
            end
            MODE_TONE, MODE_SILENCE: begin
                if (r_running) begin
                    w_status = 1'b1;
                end else begin
                    if (i_item.mode == MODE_TONE) begin
                        n_phase_inc = PHASE_BITS'(i_item.phase_step);
                    end else begin
                        n_phase_acc = '0;
                        n_phase_inc = '0;
                    end
                    n_remaining = i_item.duration_samples;
                    n_running   = (i_item.duration_samples != '0);
                end
            end
            default: begin
            end
        endcase
        n_out_item.level  = n_held_level;
        n_out_item.active = n_running;
        n_out_item.status = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc  <= '0;
            r_phase_inc  <= '0;
            r_remaining  <= '0;
            r_running    <= 1'b0;
            r_held_level <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase_acc  <= n_phase_acc;
                r_phase_inc  <= n_phase_inc;
                r_remaining  <= n_remaining;
                r_running    <= n_running;
                r_held_level <= n_held_level;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
